/* src/thsamp_pkg.sv */
// Shared types and constants for the terrain height sampler.
// Used by the front, queue, divider, back and top modules. No dependencies.
package thsamp_pkg;

	// Operation codes of the func field
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_COL_CELLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_CELLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_DIST = 2'd2;

	// Reset values of the configuration registers
	localparam logic [7:0] COL_CELLS_RST = 8'd255;
	localparam logic [7:0] ROW_CELLS_RST = 8'd255;
	localparam logic [15:0] CELL_DIST_RST = 16'd256;

	// Fixed-point widths
	localparam int FRAC_W = 16;
	localparam int FRAC_ONE = 65536;
	localparam int SX_W = 26;               // scaled position, signed
	localparam int MAG_W = 25;              // magnitude of scaled position
	localparam int DIV_W = MAG_W + FRAC_W;  // dividend and quotient bits
	localparam int REM_W = 18;              // remainder and divisor bits
	localparam int CX_W = DIV_W + 1;        // signed cell coordinate, Q.16
	localparam int Q_DEPTH = 4;

	typedef struct packed {
		logic [7:0] col_cells;
		logic [7:0] row_cells;
		logic [15:0] cell_distance;
	} cfg_t;

	typedef struct packed {
		logic func;
		logic [7:0] grid_row;
		logic [7:0] grid_col;
		logic signed [15:0] height_value;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_z;
	} item_t;

	typedef struct packed {
		logic signed [15:0] height;
		logic saturated;
	} result_t;

	// Classified item held between front and back
	typedef struct packed {
		logic wr;
		logic [15:0] wdata;
		logic [15:0] waddr;
		logic x_neg;
		logic [MAG_W-1:0] x_mag;
		logic z_neg;
		logic [MAG_W-1:0] z_mag;
	} q_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* src/thsamp_front.sv */
// Front end: accepts items, classifies writes and queries, scales positions.
// Depends on thsamp_pkg.
module thsamp_front (
	input  logic                item_valid,
	output logic                item_stall,
	input  thsamp_pkg::item_t   item,
	input  thsamp_pkg::cfg_t    cfg,
	input  thsamp_pkg::q_status_t qstat,
	output logic                push,
	output thsamp_pkg::q_item_t push_item
);

	logic [15:0] span;
	logic [23:0] prod_x;
	logic [23:0] prod_z;
	logic [8:0] stride;
	logic signed [thsamp_pkg::SX_W-1:0] sx;
	logic signed [thsamp_pkg::SX_W-1:0] sz;
	logic signed [thsamp_pkg::SX_W-1:0] sx_abs;
	logic signed [thsamp_pkg::SX_W-1:0] sz_abs;

	// Hold the source while the queue is full
	assign item_stall = qstat.full;
	assign push = item_valid && !qstat.full;

	// Double the positions and offset them by the grid extent (z is mirrored)
	always_comb begin
		span = (cfg.cell_distance == 16'd0) ? 16'd1 : cfg.cell_distance;
		prod_x = 24'(cfg.col_cells) * 24'(span);
		prod_z = 24'(cfg.row_cells) * 24'(span);
		sx = $signed(thsamp_pkg::SX_W'(prod_x))
			+ thsamp_pkg::SX_W'($signed({item.pos_x, 1'b0}));
		sz = $signed(thsamp_pkg::SX_W'(prod_z))
			- thsamp_pkg::SX_W'($signed({item.pos_z, 1'b0}));
		sx_abs = sx[thsamp_pkg::SX_W-1] ? -sx : sx;
		sz_abs = sz[thsamp_pkg::SX_W-1] ? -sz : sz;
		stride = {1'b0, cfg.col_cells} + 9'd1;
	end

	// Classify and pack the queue entry
	always_comb begin
		push_item.wr = (item.func == thsamp_pkg::FUNC_WRITE);
		push_item.wdata = item.height_value;
		push_item.waddr = 16'(item.grid_row) * 16'(stride) + 16'(item.grid_col);
		push_item.x_neg = sx[thsamp_pkg::SX_W-1];
		push_item.x_mag = sx_abs[thsamp_pkg::MAG_W-1:0];
		push_item.z_neg = sz[thsamp_pkg::SX_W-1];
		push_item.z_mag = sz_abs[thsamp_pkg::MAG_W-1:0];
	end

endmodule

/* src/thsamp_fifo.sv */
// Short queue between the front end and the back end.
// Depends on thsamp_pkg.
module thsamp_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  thsamp_pkg::q_item_t   push_item,
	input  logic                  pop,
	output thsamp_pkg::q_item_t   head,
	output thsamp_pkg::q_status_t qstat
);

	localparam int PTR_W = $clog2(thsamp_pkg::Q_DEPTH);

	thsamp_pkg::q_item_t slots_q [thsamp_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W:0] cnt_q;

	assign head = slots_q[rptr_q];
	assign qstat.full = (cnt_q == (PTR_W+1)'(thsamp_pkg::Q_DEPTH));
	assign qstat.empty = (cnt_q == '0);

	// Advance pointers and count on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (push) slots_q[wptr_q] <= push_item;
	end

endmodule

/* src/thsamp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, floor rounding.
// Depends on thsamp_pkg.
module thsamp_div (
	input  logic                                clk,
	input  logic                                en,
	input  logic [thsamp_pkg::REM_W-1:0]        den,
	input  logic                                neg,
	input  logic [thsamp_pkg::MAG_W-1:0]        mag,
	output logic signed [thsamp_pkg::CX_W-1:0]  quo
);

	localparam int DW = thsamp_pkg::DIV_W;
	localparam int RW = thsamp_pkg::REM_W;

	logic [RW-1:0] rem_s [DW];
	logic [DW-1:0] work_s [DW];
	logic neg_s [DW];
	logic [thsamp_pkg::CX_W-1:0] up;
	logic signed [thsamp_pkg::CX_W-1:0] quo_q;

	for (genvar k = 0; k < DW; k++) begin : g_step
		logic [RW-1:0] rin;
		logic [DW-1:0] win;
		logic nin;
		logic [RW-1:0] sh;
		logic take;
		if (k == 0) begin : g_first
			assign rin = '0;
			assign win = {mag, {thsamp_pkg::FRAC_W{1'b0}}};
			assign nin = neg;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign win = work_s[k-1];
			assign nin = neg_s[k-1];
		end
		// Shift in the next dividend bit and trial subtract
		assign sh = {rin[RW-2:0], win[DW-1]};
		assign take = (sh >= den);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? (sh - den) : sh;
				work_s[k] <= {win[DW-2:0], take};
				neg_s[k] <= nin;
			end
		end
	end

	// Round negative quotients toward minus infinity
	assign up = {1'b0, work_s[DW-1]} + thsamp_pkg::CX_W'(rem_s[DW-1] != '0);

	always_ff @(posedge clk) begin
		if (en) quo_q <= neg_s[DW-1] ? -$signed(up) : $signed({1'b0, work_s[DW-1]});
	end

	assign quo = quo_q;

endmodule

/* src/thsamp_back.sv */
// Back end: cell division, clamp, corner address, grid store and interpolation.
// Depends on thsamp_pkg and thsamp_div.
module thsamp_back #(
	parameter int GRID_SIDE = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  thsamp_pkg::cfg_t      cfg,
	input  thsamp_pkg::q_item_t   head,
	input  thsamp_pkg::q_status_t qstat,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output thsamp_pkg::result_t   result
);

	localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W = $clog2(GRID_DEPTH);
	localparam int RAW_W = 17;
	localparam int MOD_STEPS = (GRID_DEPTH > 65535) ? 0 : $clog2(65535 / GRID_DEPTH + 1);
	localparam int DIV_LAT = thsamp_pkg::DIV_W + 1;
	localparam int CX_W = thsamp_pkg::CX_W;
	localparam int CELL_W = CX_W - thsamp_pkg::FRAC_W;
	localparam int D_W = 17;
	localparam int LO_W = 21;
	localparam int P_W = 40;
	localparam int T_W = 60;
	localparam int H_W = 62;

	typedef struct packed {
		logic wr;
		logic [15:0] wdata;
		logic [15:0] waddr;
	} side_t;

	typedef struct packed {
		logic wr;
		logic [15:0] wdata;
		logic sel;
		logic signed [CX_W-1:0] w1;
		logic signed [CX_W-1:0] w2;
		logic [3:0][RAW_W-1:0] addr;
	} mid_t;

	function automatic logic [7:0] clamp_cell(input logic signed [CELL_W-1:0] idx,
			input logic [7:0] cells);
		logic [7:0] hi;
		logic [7:0] res;
		hi = (cells >= 8'd2) ? cells - 8'd2 : 8'd0;
		if (idx < 0) res = 8'd0;
		else if (idx > $signed({{(CELL_W-8){1'b0}}, hi})) res = hi;
		else res = idx[7:0];
		return res;
	endfunction

	logic en;
	logic [15:0] span;
	logic [thsamp_pkg::REM_W-1:0] den;
	logic signed [CX_W-1:0] cx;
	logic signed [CX_W-1:0] cz;
	side_t side_s [DIV_LAT];
	logic vld_side_s [DIV_LAT];

	logic vld_s1;
	logic wr_s1;
	logic [15:0] wdata_s1;
	logic [15:0] waddr_s1;
	logic [7:0] vcol_s1;
	logic [7:0] vrow_s1;
	logic signed [CX_W-1:0] dx_s1;
	logic signed [CX_W-1:0] dz_s1;

	logic [8:0] stride;
	logic [RAW_W-1:0] base;
	logic signed [CX_W:0] dsum;
	mid_t mid_next;
	mid_t mid_s [MOD_STEPS+1];
	logic vld_mid_s [MOD_STEPS+1];
	mid_t mid_last;

	logic vld_s3;
	logic wr_s3;
	logic sel_s3;
	logic signed [CX_W-1:0] w1_s3;
	logic signed [CX_W-1:0] w2_s3;
	logic signed [15:0] rd_s3 [4];

	logic signed [15:0] p_c;
	logic signed [15:0] q1_c;
	logic signed [15:0] q2_c;
	logic vld_s4;
	logic signed [15:0] p_s4;
	logic signed [D_W-1:0] d1_s4;
	logic signed [D_W-1:0] d2_s4;
	logic signed [CX_W-1:0] w1_s4;
	logic signed [CX_W-1:0] w2_s4;

	logic vld_s5;
	logic signed [15:0] p_s5;
	logic signed [P_W-1:0] p1l_s5;
	logic signed [P_W-1:0] p1h_s5;
	logic signed [P_W-1:0] p2l_s5;
	logic signed [P_W-1:0] p2h_s5;

	logic vld_s6;
	logic signed [15:0] p_s6;
	logic signed [T_W-1:0] t1_s6;
	logic signed [T_W-1:0] t2_s6;

	logic signed [H_W-1:0] h;
	logic pos_ovf;
	logic neg_ovf;
	thsamp_pkg::result_t res_c;
	logic result_valid_q;
	thsamp_pkg::result_t result_q;

	// Stall the whole back end only while a result waits unclaimed
	assign en = !(result_valid_q && result_stall);
	assign pop = en && !qstat.empty;

	assign span = (cfg.cell_distance == 16'd0) ? 16'd1 : cfg.cell_distance;
	assign den = {1'b0, span, 1'b0};

	thsamp_div u_div_x (
		.clk (clk),
		.en  (en),
		.den (den),
		.neg (head.x_neg),
		.mag (head.x_mag),
		.quo (cx)
	);

	thsamp_div u_div_z (
		.clk (clk),
		.en  (en),
		.den (den),
		.neg (head.z_neg),
		.mag (head.z_mag),
		.quo (cz)
	);

	// Carry item kind and write data alongside the dividers
	for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
		if (k == 0) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld_side_s[k] <= 1'b0;
				else if (en) vld_side_s[k] <= pop;
			end
			always_ff @(posedge clk) begin
				if (en) begin
					side_s[k].wr <= head.wr;
					side_s[k].wdata <= head.wdata;
					side_s[k].waddr <= head.waddr;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld_side_s[k] <= 1'b0;
				else if (en) vld_side_s[k] <= vld_side_s[k-1];
			end
			always_ff @(posedge clk) begin
				if (en) side_s[k] <= side_s[k-1];
			end
		end
	end

	// Clamp the cell and take the offsets inside it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= vld_side_s[DIV_LAT-1];
	end

	always_ff @(posedge clk) begin
		logic [7:0] vc;
		logic [7:0] vr;
		if (en) begin
			vc = clamp_cell(cx[CX_W-1:thsamp_pkg::FRAC_W], cfg.col_cells);
			vr = clamp_cell(cz[CX_W-1:thsamp_pkg::FRAC_W], cfg.row_cells);
			wr_s1 <= side_s[DIV_LAT-1].wr;
			wdata_s1 <= side_s[DIV_LAT-1].wdata;
			waddr_s1 <= side_s[DIV_LAT-1].waddr;
			vcol_s1 <= vc;
			vrow_s1 <= vr;
			dx_s1 <= cx - $signed(CX_W'({vc, 16'h0000}));
			dz_s1 <= cz - $signed(CX_W'({vr, 16'h0000}));
		end
	end

	// Form corner addresses, pick the triangle and its weights
	always_comb begin
		stride = {1'b0, cfg.col_cells} + 9'd1;
		base = RAW_W'(vrow_s1) * RAW_W'(stride) + RAW_W'(vcol_s1);
		dsum = {dx_s1[CX_W-1], dx_s1} + {dz_s1[CX_W-1], dz_s1};
		mid_next.wr = wr_s1;
		mid_next.wdata = wdata_s1;
		mid_next.sel = (dsum < (CX_W+1)'(thsamp_pkg::FRAC_ONE));
		mid_next.w1 = mid_next.sel ? dx_s1 : CX_W'(thsamp_pkg::FRAC_ONE) - dx_s1;
		mid_next.w2 = mid_next.sel ? dz_s1 : CX_W'(thsamp_pkg::FRAC_ONE) - dz_s1;
		if (wr_s1) begin
			mid_next.addr[0] = RAW_W'(waddr_s1);
			mid_next.addr[1] = RAW_W'(waddr_s1);
			mid_next.addr[2] = RAW_W'(waddr_s1);
			mid_next.addr[3] = RAW_W'(waddr_s1);
		end else begin
			mid_next.addr[0] = base;
			mid_next.addr[1] = base + RAW_W'(1);
			mid_next.addr[2] = base + RAW_W'(stride);
			mid_next.addr[3] = base + RAW_W'(stride) + RAW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_mid_s[0] <= 1'b0;
		else if (en) vld_mid_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) mid_s[0] <= mid_next;
	end

	// Wrap addresses into the grid depth, one conditional subtract per stage
	for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
		localparam logic [RAW_W-1:0] SUB = RAW_W'(GRID_DEPTH << (MOD_STEPS - 1 - j));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_mid_s[j+1] <= 1'b0;
			else if (en) vld_mid_s[j+1] <= vld_mid_s[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				mid_s[j+1].wr <= mid_s[j].wr;
				mid_s[j+1].wdata <= mid_s[j].wdata;
				mid_s[j+1].sel <= mid_s[j].sel;
				mid_s[j+1].w1 <= mid_s[j].w1;
				mid_s[j+1].w2 <= mid_s[j].w2;
				for (int b = 0; b < 4; b++) begin
					mid_s[j+1].addr[b] <= (mid_s[j].addr[b] >= SUB)
						? mid_s[j].addr[b] - SUB : mid_s[j].addr[b];
				end
			end
		end
	end

	assign mid_last = mid_s[MOD_STEPS];

	// Grid store: four copies, each written by every write, each read at one corner
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [15:0] store [GRID_DEPTH];
		always_ff @(posedge clk) begin
			if (en && vld_mid_s[MOD_STEPS]) begin
				if (mid_last.wr) store[ADDR_W'(mid_last.addr[b])] <= mid_last.wdata;
				else rd_s3[b] <= $signed(store[ADDR_W'(mid_last.addr[b])]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_mid_s[MOD_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wr_s3 <= mid_last.wr;
			sel_s3 <= mid_last.sel;
			w1_s3 <= mid_last.w1;
			w2_s3 <= mid_last.w2;
		end
	end

	// Take corner differences for the chosen triangle; drop write items here
	always_comb begin
		p_c = sel_s3 ? rd_s3[0] : rd_s3[3];
		q1_c = sel_s3 ? rd_s3[1] : rd_s3[2];
		q2_c = sel_s3 ? rd_s3[2] : rd_s3[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3 && !wr_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4 <= p_c;
			d1_s4 <= D_W'(q1_c) - D_W'(p_c);
			d2_s4 <= D_W'(q2_c) - D_W'(p_c);
			w1_s4 <= w1_s3;
			w2_s4 <= w2_s3;
		end
	end

	// Multiply differences by weights split into low and high halves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5 <= p_s4;
			p1l_s5 <= P_W'(d1_s4 * $signed({1'b0, w1_s4[LO_W-1:0]}));
			p1h_s5 <= P_W'(d1_s4 * $signed(w1_s4[CX_W-1:LO_W]));
			p2l_s5 <= P_W'(d2_s4 * $signed({1'b0, w2_s4[LO_W-1:0]}));
			p2h_s5 <= P_W'(d2_s4 * $signed(w2_s4[CX_W-1:LO_W]));
		end
	end

	// Recombine the partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s6 <= p_s5;
			t1_s6 <= (T_W'(p1h_s5) <<< LO_W) + T_W'(p1l_s5);
			t2_s6 <= (T_W'(p2h_s5) <<< LO_W) + T_W'(p2l_s5);
		end
	end

	// Add the base height, round to Q8.8 and saturate
	always_comb begin
		h = (H_W'(p_s6) <<< thsamp_pkg::FRAC_W) + H_W'(t1_s6) + H_W'(t2_s6)
			+ H_W'(thsamp_pkg::FRAC_ONE / 2);
		pos_ovf = !h[H_W-1] && (|h[H_W-2:31]);
		neg_ovf = h[H_W-1] && !(&h[H_W-2:31]);
		res_c.saturated = pos_ovf || neg_ovf;
		if (pos_ovf) res_c.height = 16'sh7fff;
		else if (neg_ovf) res_c.height = 16'sh8000;
		else res_c.height = $signed(h[31:16]);
	end

	// Output register: load whenever the back end advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid_q <= 1'b0;
		else if (en) result_valid_q <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (en) result_q <= res_c;
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

/* src/terrain_height_sample.sv */
// Terrain height sampler: one item per cycle sustained, write or query, while
// result_stall holds no result. An item passes the queue, the 41-stage cell divider,
// the clamp, the corner address register, the address wrap stages (0 for GRID_SIDE
// 256, up to 12 for 4), the grid read, the interpolation registers and the output
// register; the divider makes up most of that path. Reset clears control state and
// loads the configuration defaults; grid contents are undefined until written.
module terrain_height_sample #(
	parameter int GRID_SIDE = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [thsamp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [thsamp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  thsamp_pkg::item_t                     item,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output thsamp_pkg::result_t                   result
);

	thsamp_pkg::cfg_t cfg_q;
	thsamp_pkg::q_status_t qstat;
	thsamp_pkg::q_item_t push_item;
	thsamp_pkg::q_item_t head;
	logic push;
	logic pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.col_cells <= thsamp_pkg::COL_CELLS_RST;
			cfg_q.row_cells <= thsamp_pkg::ROW_CELLS_RST;
			cfg_q.cell_distance <= thsamp_pkg::CELL_DIST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				thsamp_pkg::REG_COL_CELLS: cfg_q.col_cells <= cfg_data[7:0];
				thsamp_pkg::REG_ROW_CELLS: cfg_q.row_cells <= cfg_data[7:0];
				thsamp_pkg::REG_CELL_DIST: cfg_q.cell_distance <= cfg_data;
				default: ;
			endcase
		end
	end

	thsamp_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg_q),
		.qstat      (qstat),
		.push       (push),
		.push_item  (push_item)
	);

	thsamp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	thsamp_back #(
		.GRID_SIDE (GRID_SIDE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
